FILE: rtl/xle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML literal escaper package
// Shared types and character constants for the escaper front, queue and back.
// ----------------------------------------------------------------------------
package xle_pkg;

	localparam int unsigned MAX_RUN = 6;
	localparam int unsigned RUN_W   = 3;

	typedef logic [7:0] char_t;
	typedef logic [RUN_W-1:0] run_len_t;
	typedef logic [MAX_RUN-1:0][7:0] run_bytes_t;

	// One classified transaction: the full escaped run and its length.
	typedef struct packed {
		run_bytes_t run_bytes;
		run_len_t   run_len;
	} run_desc_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef enum logic [1:0] {
		CLS_PLAIN,
		CLS_ENTITY,
		CLS_NUMERIC
	} char_class_t;

	localparam char_t CH_AMP   = 8'h26;
	localparam char_t CH_HASH  = 8'h23;
	localparam char_t CH_SEMI  = 8'h3B;
	localparam char_t CH_LT    = 8'h3C;
	localparam char_t CH_GT    = 8'h3E;
	localparam char_t CH_APOS  = 8'h27;
	localparam char_t CH_QUOT  = 8'h22;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TILDE = 8'h7E;
	localparam char_t CH_NUL   = 8'h00;

	localparam char_t CH_A = 8'h61;
	localparam char_t CH_G = 8'h67;
	localparam char_t CH_L = 8'h6C;
	localparam char_t CH_M = 8'h6D;
	localparam char_t CH_O = 8'h6F;
	localparam char_t CH_P = 8'h70;
	localparam char_t CH_Q = 8'h71;
	localparam char_t CH_S = 8'h73;
	localparam char_t CH_T = 8'h74;
	localparam char_t CH_U = 8'h75;

endpackage

FILE: rtl/xml_literal_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML literal escaper core
// Turns raw text bytes into their XML-safe form, one output byte per clock.
// ----------------------------------------------------------------------------
// A text byte is taken as a transaction on any rising edge where start is
// high and busy is low. Printable ASCII passes through as a single byte, the
// five markup characters become their named entities, and every other byte
// becomes a decimal numeric reference such as "&#9;" or "&#200;". The
// escaped run leaves on out_byte one byte per cycle, each marked by a
// one-cycle result_valid pulse, with run_last set on the final byte of the
// run. The receiver has no way to stall: it must take every byte in the cycle
// it appears. Each input byte therefore yields one to six output bytes
// (one for plain bytes, four to six for entities and numeric references),
// and that output serializer sets the sustained rate. The front end
// classifies a byte in the cycle it arrives and drops the whole run into a
// QUEUE_DEPTH-entry queue, so input keeps flowing at one byte per cycle
// until the queue fills; busy is high exactly while the queue is full. When the
// queue is empty, a taken byte is written into a queue entry and its first
// output byte then leaves through the back end's output registers. No
// configuration; the state is the queue, the back end's run index and its output registers.
// ----------------------------------------------------------------------------
module xml_literal_escaper_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  xle_pkg::char_t text_byte,
	output logic           result_valid,
	output xle_pkg::char_t out_byte,
	output logic           run_last
);

	xle_pkg::run_desc_t     front_desc;
	xle_pkg::run_desc_t     head_desc;
	xle_pkg::queue_status_t q_status;
	logic                   pop;
	logic                   accept;

	// Busy depends only on queue occupancy, never on start.
	assign busy   = q_status.full;
	assign accept = start && !busy;

	// Front end: classification and run building happen combinationally on
	// the incoming byte; the queue register captures the result.
	xle_front u_front (
		.text_byte (text_byte),
		.desc      (front_desc)
	);

	// Decoupling queue: lets the front keep accepting while the back is still
	// draining a long run.
	xle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_desc (front_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.status    (q_status)
	);

	// Back end: walks the head run byte by byte into the output registers and
	// retires the entry on its last byte.
	xle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_desc    (head_desc),
		.status       (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

endmodule

FILE: rtl/xle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML literal escaper front end
// Classifies one text byte and builds its complete escaped run.
// ----------------------------------------------------------------------------
module xle_front (
	input  xle_pkg::char_t    text_byte,
	output xle_pkg::run_desc_t desc
);

	xle_pkg::char_class_t cls;
	logic [1:0]  hundreds;
	logic [7:0]  rem_hund;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [7:0]  ones;
	xle_pkg::char_t d_hund;
	xle_pkg::char_t d_tens;
	xle_pkg::char_t d_ones;

	always_comb begin
		if (text_byte < xle_pkg::CH_SPACE || text_byte > xle_pkg::CH_TILDE) begin
			cls = xle_pkg::CLS_NUMERIC;
		end else if (text_byte == xle_pkg::CH_LT || text_byte == xle_pkg::CH_GT ||
				text_byte == xle_pkg::CH_AMP || text_byte == xle_pkg::CH_APOS ||
				text_byte == xle_pkg::CH_QUOT) begin
			cls = xle_pkg::CLS_ENTITY;
		end else begin
			cls = xle_pkg::CLS_PLAIN;
		end
	end

	// Decimal split: the remainder below 100 is divided by ten through a
	// reciprocal multiply, which is exact for every value under 179.
	always_comb begin
		if (text_byte >= 8'd200) begin
			hundreds = 2'd2;
			rem_hund = text_byte - 8'd200;
		end else if (text_byte >= 8'd100) begin
			hundreds = 2'd1;
			rem_hund = text_byte - 8'd100;
		end else begin
			hundreds = 2'd0;
			rem_hund = text_byte;
		end
		tens_prod = {8'd0, rem_hund[6:0]} * 15'd205;
		tens      = tens_prod[14:11];
		ones      = rem_hund - 8'({tens, 3'b000} + {tens, 1'b0});
		d_hund    = xle_pkg::CH_ZERO + 8'(hundreds);
		d_tens    = xle_pkg::CH_ZERO + 8'(tens);
		d_ones    = xle_pkg::CH_ZERO + ones;
	end

	always_comb begin
		desc.run_bytes = '{default: xle_pkg::CH_NUL};
		desc.run_len   = 3'd1;
		unique case (cls)
			xle_pkg::CLS_NUMERIC: begin
				desc.run_bytes[0] = xle_pkg::CH_AMP;
				desc.run_bytes[1] = xle_pkg::CH_HASH;
				if (text_byte >= 8'd100) begin
					desc.run_bytes[2] = d_hund;
					desc.run_bytes[3] = d_tens;
					desc.run_bytes[4] = d_ones;
					desc.run_bytes[5] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd6;
				end else if (text_byte >= 8'd10) begin
					desc.run_bytes[2] = d_tens;
					desc.run_bytes[3] = d_ones;
					desc.run_bytes[4] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd5;
				end else begin
					desc.run_bytes[2] = d_ones;
					desc.run_bytes[3] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd4;
				end
			end
			xle_pkg::CLS_ENTITY: begin
				desc.run_bytes[0] = xle_pkg::CH_AMP;
				priority if (text_byte == xle_pkg::CH_LT) begin
					desc.run_bytes[1] = xle_pkg::CH_L;
					desc.run_bytes[2] = xle_pkg::CH_T;
					desc.run_bytes[3] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd4;
				end else if (text_byte == xle_pkg::CH_GT) begin
					desc.run_bytes[1] = xle_pkg::CH_G;
					desc.run_bytes[2] = xle_pkg::CH_T;
					desc.run_bytes[3] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd4;
				end else if (text_byte == xle_pkg::CH_AMP) begin
					desc.run_bytes[1] = xle_pkg::CH_A;
					desc.run_bytes[2] = xle_pkg::CH_M;
					desc.run_bytes[3] = xle_pkg::CH_P;
					desc.run_bytes[4] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd5;
				end else if (text_byte == xle_pkg::CH_APOS) begin
					desc.run_bytes[1] = xle_pkg::CH_A;
					desc.run_bytes[2] = xle_pkg::CH_P;
					desc.run_bytes[3] = xle_pkg::CH_O;
					desc.run_bytes[4] = xle_pkg::CH_S;
					desc.run_bytes[5] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd6;
				end else begin
					desc.run_bytes[1] = xle_pkg::CH_Q;
					desc.run_bytes[2] = xle_pkg::CH_U;
					desc.run_bytes[3] = xle_pkg::CH_O;
					desc.run_bytes[4] = xle_pkg::CH_T;
					desc.run_bytes[5] = xle_pkg::CH_SEMI;
					desc.run_len      = 3'd6;
				end
			end
			default: begin
				desc.run_bytes[0] = text_byte;
				desc.run_len      = 3'd1;
			end
		endcase
	end

endmodule

FILE: rtl/xle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML literal escaper run queue
// Small FIFO of classified runs between the front and back ends.
// ----------------------------------------------------------------------------
module xle_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  xle_pkg::run_desc_t     push_desc,
	input  logic                   pop,
	output xle_pkg::run_desc_t     head_desc,
	output xle_pkg::queue_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	xle_pkg::run_desc_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_desc    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/xle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML literal escaper back end
// Serializes the run at the queue head, one byte per clock, into registers.
// ----------------------------------------------------------------------------
module xle_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  xle_pkg::run_desc_t     head_desc,
	input  xle_pkg::queue_status_t status,
	output logic                   pop,
	output logic                   result_valid,
	output xle_pkg::char_t         out_byte,
	output logic                   run_last
);

	xle_pkg::run_len_t idx_q;
	logic              last_byte;
	logic              result_valid_q;
	xle_pkg::char_t    out_byte_q;
	logic              run_last_q;

	assign last_byte = (idx_q == xle_pkg::RUN_W'(head_desc.run_len - 3'd1));
	assign pop       = !status.empty && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= !status.empty;
			if (!status.empty) begin
				idx_q <= last_byte ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_byte_q <= head_desc.run_bytes[idx_q];
		run_last_q <= last_byte;
	end

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;

endmodule
